// ----- rtl/tree_ancestral_categorical_sampler_assert.svh -----
// Assertion macros for the tree sampler.
`ifndef TREE_ANCESTRAL_CATEGORICAL_SAMPLER_ASSERT_SVH
`define TREE_ANCESTRAL_CATEGORICAL_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TACS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TACS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TACS_ASSERT(label, clk, rst, prop, msg)
`define TACS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/tacs_pkg.sv -----
// Shared constants and types for the tree sampler.
package tacs_pkg;
  localparam int DEF_MAX_HIDDEN = 16;
  localparam int DEF_MAX_VOCAB  = 128;
  localparam int DEF_MAX_LEVELS = 8;
  localparam int DEF_MAX_DEGREE = 4;
  localparam int DEF_PROB_BITS  = 16;

  localparam logic [1:0] ACT_ROOT = 2'd0;
  localparam logic [1:0] ACT_HID  = 2'd1;
  localparam logic [1:0] ACT_EMIT = 2'd2;
  localparam logic [1:0] ACT_DRAW = 2'd3;

  localparam logic [1:0] REG_BRANCHING = 2'd0;
  localparam logic [1:0] REG_LEVELS    = 2'd1;
  localparam logic [1:0] REG_HIDDEN    = 2'd2;
  localparam logic [1:0] REG_VOCAB     = 2'd3;

  localparam logic [1:0] TBL_ROOT = 2'd0;
  localparam logic [1:0] TBL_HID  = 2'd1;
  localparam logic [1:0] TBL_EMIT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // write table entry from input word
    logic       start;      // begin search on input word
    logic       step;       // read data valid, narrow interval
    logic       commit;     // search done, update traversal
  } tacs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       done;       // interval closed
    logic       is_leaf;    // node being sampled is a leaf
  } tacs_stat_t;
endpackage

// ----- rtl/tacs_ctrl.sv -----
// Controller state machine for the tree sampler.
module tacs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic                out_busy,
  input  tacs_pkg::tacs_stat_t stat,
  output tacs_pkg::tacs_cmd_t  cmd
);
  import tacs_pkg::*;
  `include "tree_ancestral_categorical_sampler_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic       take;

  // a leaf commit needs the output register free
  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (action == ACT_DRAW) begin
            cmd.start = 1'b1;
            state_next = S_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_READ: begin
        state_next = stat.done ? S_DONE : S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_next = S_READ;
      end
      S_DONE: begin
        if (!(stat.is_leaf && out_busy)) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `TACS_ASSERT(a_one_cmd, clk, rst, $onehot0({cmd.load, cmd.start, cmd.step, cmd.commit}), "two commands at once")
  `TACS_ASSERT(a_start_read, clk, rst, cmd.start |=> (state == S_READ), "start did not enter search")
  `TACS_ASSERT(a_commit_idle, clk, rst, cmd.commit |=> (state == S_IDLE), "commit did not finish")
endmodule

// ----- rtl/tacs_dp.sv -----
// Datapath: cdf tables, binary search, traversal stack and output register.
module tacs_dp #(
  parameter int MAX_HIDDEN = tacs_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_VOCAB  = tacs_pkg::DEF_MAX_VOCAB,
  parameter int MAX_LEVELS = tacs_pkg::DEF_MAX_LEVELS,
  parameter int MAX_DEGREE = tacs_pkg::DEF_MAX_DEGREE,
  parameter int PROB_BITS  = tacs_pkg::DEF_PROB_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tacs_pkg::tacs_cmd_t  cmd,
  output tacs_pkg::tacs_stat_t stat,
  input  logic [1:0]           action,
  input  logic [6:0]           table_row,
  input  logic [3:0]           table_col,
  input  logic [15:0]          cdf_value,
  input  logic [15:0]          random_value,
  input  logic [2:0]           branching,
  input  logic [3:0]           level_count,
  input  logic [4:0]           hidden_count,
  input  logic [7:0]           vocab_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [13:0]          leaf_index,
  output logic [6:0]           symbol,
  output logic                 last_leaf
);
  import tacs_pkg::*;
  `include "tree_ancestral_categorical_sampler_assert.svh"

  localparam int HB = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int VB = (MAX_VOCAB > 1) ? $clog2(MAX_VOCAB) : 1;
  localparam int LB = $clog2(MAX_LEVELS);
  localparam int CB = $clog2(MAX_DEGREE + 1);
  localparam int RB = (VB > HB) ? VB : HB;   // search index width
  localparam int PB = (PROB_BITS < 16) ? PROB_BITS : 16;
  localparam int HIB = $clog2(MAX_HIDDEN * MAX_HIDDEN);
  localparam int EIB = $clog2(MAX_VOCAB * MAX_HIDDEN);

  logic [PB-1:0] root_mem [MAX_HIDDEN];
  logic [PB-1:0] hid_mem  [MAX_HIDDEN*MAX_HIDDEN];
  logic [PB-1:0] emit_mem [MAX_VOCAB*MAX_HIDDEN];

  logic [HB-1:0] lvl_state [MAX_LEVELS];
  logic [CB-1:0] child_cnt [MAX_LEVELS];
  logic [LB-1:0] depth;
  logic [13:0]   leaf_cnt;

  // clamped configuration
  logic [CB-1:0] deg;
  logic [LB-1:0] leaf_lvl;
  logic [RB:0]   nh, nv;
  always_comb begin
    if (branching < 3'd2) deg = CB'(2);
    else if (32'(branching) > MAX_DEGREE) deg = CB'(MAX_DEGREE);
    else deg = CB'(branching);
    if (level_count < 4'd2) leaf_lvl = LB'(1);
    else if (32'(level_count) > MAX_LEVELS) leaf_lvl = LB'(MAX_LEVELS - 1);
    else leaf_lvl = LB'(level_count - 4'd1);
    if (hidden_count == 5'd0) nh = (RB+1)'(1);
    else if (32'(hidden_count) > MAX_HIDDEN) nh = (RB+1)'(MAX_HIDDEN);
    else nh = (RB+1)'(hidden_count);
    if (vocab_count == 8'd0) nv = (RB+1)'(1);
    else if (32'(vocab_count) > MAX_VOCAB) nv = (RB+1)'(MAX_VOCAB);
    else nv = (RB+1)'(vocab_count);
  end

  // search registers
  logic [1:0]    tbl;
  logic [LB-1:0] d;
  logic [HB-1:0] col;
  logic [RB-1:0] lo, hi, mid;
  logic [PB-1:0] rnd, rd_data;

  logic [LB-1:0] d_in;
  always_comb d_in = (depth > leaf_lvl) ? leaf_lvl : depth;
  assign mid = RB'((({1'b0, lo} + {1'b0, hi}) >> 1));

  assign stat.done    = (lo == hi);
  assign stat.is_leaf = (tbl == TBL_EMIT);

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (action)
        ACT_ROOT:
          if (32'(table_row) < MAX_HIDDEN) root_mem[HB'(table_row)] <= PB'(cdf_value);
        ACT_HID:
          if (32'(table_row) < MAX_HIDDEN && 32'(table_col) < MAX_HIDDEN)
            hid_mem[HIB'(HB'(table_row) * MAX_HIDDEN + HB'(table_col))] <= PB'(cdf_value);
        ACT_EMIT:
          if (32'(table_row) < MAX_VOCAB && 32'(table_col) < MAX_HIDDEN)
            emit_mem[EIB'(VB'(table_row) * MAX_HIDDEN + HB'(table_col))] <= PB'(cdf_value);
        default: ;
      endcase
    end
    case (tbl)
      TBL_ROOT: rd_data <= root_mem[HB'(mid)];
      TBL_HID:  rd_data <= hid_mem[HIB'(HB'(mid) * MAX_HIDDEN + col)];
      default:  rd_data <= emit_mem[EIB'(VB'(mid) * MAX_HIDDEN + col)];
    endcase
  end

  // search interval
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rnd <= PB'(random_value);
      d   <= d_in;
      lo  <= '0;
      if (d_in == '0) begin
        tbl <= TBL_ROOT;
        col <= '0;
        hi  <= RB'(nh - 1'b1);
      end else if (d_in < leaf_lvl) begin
        tbl <= TBL_HID;
        col <= lvl_state[d_in - 1'b1];
        hi  <= RB'(nh - 1'b1);
      end else begin
        tbl <= TBL_EMIT;
        col <= lvl_state[d_in - 1'b1];
        hi  <= RB'(nv - 1'b1);
      end
    end else if (cmd.step) begin
      if (rd_data < rnd) lo <= RB'(mid + 1'b1);
      else               hi <= mid;
    end
  end

  // climb: after the leaf, pop full levels upward until one is not full (counts include this leaf)
  logic [LB-1:0] climb;
  logic [CB-1:0] cnt_bump [MAX_LEVELS];
  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++)
      cnt_bump[i] = (LB'(i) == d - 1'b1) ? CB'(child_cnt[i] + 1'b1) : child_cnt[i];
    climb = d;
    for (int i = MAX_LEVELS - 1; i >= 0; i--)
      if (LB'(i) < d && (LB'(i) == climb - 1'b1) && cnt_bump[i] >= deg)
        climb = LB'(i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      leaf_cnt <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        lvl_state[i] <= '0;
        child_cnt[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.commit) begin
        if (tbl == TBL_ROOT) begin
          lvl_state[0] <= HB'(lo);
          child_cnt[0] <= '0;
          depth <= LB'(1);
        end else if (tbl == TBL_HID) begin
          lvl_state[d] <= HB'(lo);
          child_cnt[d] <= '0;
          child_cnt[d - 1'b1] <= CB'(child_cnt[d - 1'b1] + 1'b1);
          depth <= LB'(d + 1'b1);
        end else begin
          for (int i = 0; i < MAX_LEVELS; i++)
            if (LB'(i) < d && LB'(i) >= climb) child_cnt[i] <= '0;
            else if (LB'(i) == d - 1'b1) child_cnt[i] <= cnt_bump[i];
          out_valid  <= 1'b1;
          leaf_index <= leaf_cnt;
          symbol     <= 7'(lo);
          last_leaf  <= (climb == '0);
          depth      <= climb;
          leaf_cnt   <= (climb == '0) ? 14'd0 : 14'(leaf_cnt + 1'b1);
        end
      end
    end
  end

  `TACS_ASSERT(a_no_overrun, clk, rst, (cmd.commit && stat.is_leaf) |-> (!out_valid || !out_stall), "leaf result overwrote pending word")
  `TACS_ASSERT(a_lo_le_hi, clk, rst, cmd.step |=> (lo <= hi), "search interval inverted")
  `TACS_ASSERT(a_last_root, clk, rst, (cmd.commit && stat.is_leaf && climb == '0) |=> (depth == '0), "tree end did not return to root")
endmodule

// ----- rtl/tacs_cfg.sv -----
// Configuration register file.
module tacs_cfg (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic [2:0] branching,
  output logic [3:0] level_count,
  output logic [4:0] hidden_count,
  output logic [7:0] vocab_count
);
  import tacs_pkg::*;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      branching <= 3'd2;
      level_count <= 4'd2;
      hidden_count <= 5'd16;
      vocab_count <= 8'd128;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BRANCHING: branching    <= cfg_data[2:0];
        REG_LEVELS:    level_count  <= cfg_data[3:0];
        REG_HIDDEN:    hidden_count <= cfg_data[4:0];
        REG_VOCAB:     vocab_count  <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/tree_ancestral_categorical_sampler.sv -----
// Top level of the tree ancestral categorical sampler.
// Usage:
//  Input channel (in_valid/in_stall) takes one word per item: action selects a
//  table load (root, hidden, emission) or a draw using random_value.
//  A load is written to its table as it is accepted. A draw binary-searches
//  one cdf column through the registered table read port, each probe a table
//  read and then a narrowing step, until the interval closes and it commits.
//  One item is in flight at a time; in_stall is high while a draw runs.
//  Output channel (out_valid/out_stall) carries leaf_index, symbol, last_leaf
//  for each leaf draw, from a register loaded at that draw's commit.
//  A stalled result holds; a following draw proceeds, and a leaf draw waits
//  only at its own commit if the result register is still full.
//  Config channel (cfg_valid/cfg_ready) writes branching, level_count,
//  hidden_count, vocab_count by index; ready is always high.
//  Reset returns the traversal to the root, clears counters and registers to
//  their defaults; table contents are undefined until loaded.
module tree_ancestral_categorical_sampler #(
  parameter int MAX_HIDDEN = tacs_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_VOCAB  = tacs_pkg::DEF_MAX_VOCAB,
  parameter int MAX_LEVELS = tacs_pkg::DEF_MAX_LEVELS,
  parameter int MAX_DEGREE = tacs_pkg::DEF_MAX_DEGREE,
  parameter int PROB_BITS  = tacs_pkg::DEF_PROB_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [6:0]  table_row,
  input  logic [3:0]  table_col,
  input  logic [15:0] cdf_value,
  input  logic [15:0] random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] leaf_index,
  output logic [6:0]  symbol,
  output logic        last_leaf,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tacs_pkg::*;

  tacs_cmd_t  cmd;
  tacs_stat_t stat;
  logic [2:0] branching;
  logic [3:0] level_count;
  logic [4:0] hidden_count;
  logic [7:0] vocab_count;

  tacs_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .branching, .level_count, .hidden_count, .vocab_count
  );

  tacs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .action,
    .out_busy(out_valid && out_stall), .stat, .cmd
  );

  tacs_dp #(
    .MAX_HIDDEN(MAX_HIDDEN), .MAX_VOCAB(MAX_VOCAB), .MAX_LEVELS(MAX_LEVELS),
    .MAX_DEGREE(MAX_DEGREE), .PROB_BITS(PROB_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .action, .table_row, .table_col, .cdf_value,
    .random_value, .branching, .level_count, .hidden_count, .vocab_count,
    .out_valid, .out_stall, .leaf_index, .symbol, .last_leaf
  );
endmodule
